/* sv/bmp_rle8_decoder_defines.svh */
// Assertion macros shared by the run-length decoder RTL.
`ifndef BMP_RLE8_DECODER_DEFINES_SVH
`define BMP_RLE8_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRLE8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BRLE8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/brle8_pkg.sv */
// Types and constants of the run-length decoder.
package brle8_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] ESC_EOL   = 8'h00;
	localparam logic [ByteW-1:0] ESC_EOB   = 8'h01;
	localparam logic [ByteW-1:0] ESC_DELTA = 8'h02;

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_DELTA1  = 3'd2,
		PH_DELTA2  = 3'd3,
		PH_LITERAL = 3'd4,
		PH_PAD     = 3'd5
	} phase_t;

	typedef struct packed {
		logic             emit;
		logic [ByteW-1:0] pixel_index;
		logic [ByteW-1:0] repeat_count;
		logic             bitmap_end;
	} res_t;

endpackage

/* sv/bmp_rle8_decoder.sv */
// Top level of the run-length decoder for 8-bit bitmap pixel data.
// Coded bytes arrive on the input channel (in_valid, in_ready, stream_byte), one per
// transfer. Run descriptors leave on the output channel (out_valid, out_ready,
// pixel_index, repeat_count, bitmap_end): a counted pair gives one run, each literal
// byte gives a run of one, and the end-of-bitmap escape gives an end marker with a
// zero count. End-of-line, delta bytes and pad bytes give nothing.
// A byte is held in an input register; its state update and result are formed there
// and the result is written to the output register. out_valid rises at the clock edge
// at which the byte leaves the input register, which a stalled output can delay.
// One byte is taken per cycle, set by the single state update per byte, while the
// output is taken or the bytes produce no result.
// When the receiver stalls, the result waits in the output register and the byte
// behind it waits in the input register; bytes that produce no result keep flowing.
// Asynchronous reset clears the valid flags of both registers and returns the decoder
// to await the first pair of a new bitmap.
`include "bmp_rle8_decoder_defines.svh"
module bmp_rle8_decoder import brle8_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] stream_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ByteW-1:0] pixel_index,
	output logic [ByteW-1:0] repeat_count,
	output logic             bitmap_end
);

	logic             v_s1;
	logic [ByteW-1:0] byte_s1;
	logic             adv;
	res_t             res;
	logic             out_v_q;
	logic [ByteW-1:0] idx_q;
	logic [ByteW-1:0] cnt_q;
	logic             end_q;

	// A byte leaves the input register when its result has room or it has none.
	assign adv      = v_s1 && (!res.emit || !out_v_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	brle8_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			idx_q <= res.pixel_index;
			cnt_q <= res.repeat_count;
			end_q <= res.bitmap_end;
		end
	end

	assign out_valid    = out_v_q;
	assign pixel_index  = idx_q;
	assign repeat_count = cnt_q;
	assign bitmap_end   = end_q;

	`BRLE8_ASSERT_NOW(a_end_zero, out_valid && bitmap_end,
		pixel_index == '0 && repeat_count == '0, "end marker carries nonzero fields")
	`BRLE8_ASSERT_NOW(a_run_nonzero, out_valid && !bitmap_end,
		repeat_count != '0, "run result with zero count")
	`BRLE8_ASSERT_NEXT(a_s1_hold, v_s1 && !adv,
		v_s1 && $stable(byte_s1), "stalled byte lost from input register")

endmodule

/* sv/brle8_core.sv */
// Decoder state machine: consumes one coded byte per step and forms the run result.
module brle8_core import brle8_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [ByteW-1:0] byte_in,
	output res_t             res
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] held_q, held_d;
	logic [ByteW-1:0] left_q, left_d;
	logic             pad_q, pad_d;
	logic [ByteW-1:0] left_dec;

	assign left_dec = left_q - ByteW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= '0;
			left_q  <= '0;
			pad_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			left_q  <= left_d;
			pad_q   <= pad_d;
		end
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		left_d  = left_q;
		pad_d   = pad_q;
		case (phase_q)
			PH_SECOND: begin
				phase_d = PH_FIRST;
				if (held_q == '0) begin
					case (byte_in)
						ESC_EOL: phase_d = PH_FIRST;
						ESC_EOB: begin
							left_d = '0;
							pad_d  = 1'b0;
						end
						ESC_DELTA: phase_d = PH_DELTA1;
						default: begin
							left_d  = byte_in;
							pad_d   = byte_in[0];
							phase_d = PH_LITERAL;
						end
					endcase
				end
			end
			PH_DELTA1: phase_d = PH_DELTA2;
			PH_DELTA2: phase_d = PH_FIRST;
			PH_LITERAL: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = pad_q ? PH_PAD : PH_FIRST;
				end
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_FIRST;
			end
			default: begin
				held_d  = byte_in;
				phase_d = PH_SECOND;
			end
		endcase
	end

	// Result of the current byte.
	always_comb begin
		res = '0;
		case (phase_q)
			PH_SECOND: begin
				if (held_q != '0) begin
					res.emit         = 1'b1;
					res.pixel_index  = byte_in;
					res.repeat_count = held_q;
				end else if (byte_in == ESC_EOB) begin
					res.emit       = 1'b1;
					res.bitmap_end = 1'b1;
				end
			end
			PH_LITERAL: begin
				res.emit         = 1'b1;
				res.pixel_index  = byte_in;
				res.repeat_count = ByteW'(1);
			end
			default: res = '0;
		endcase
	end

endmodule
